// File: design/fslts_pkg.sv
`timescale 1ns / 1ps

package fslts_pkg;

    localparam int SPEED_W   = 7;
    localparam int DRIVE_W   = 2;
    localparam int CODE_W    = 4;
    localparam int HOLD_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int NPAT      = 9;

    // drive commands
    localparam logic [DRIVE_W-1:0] DRIVE_STOP    = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_FORWARD = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_LEFT    = 2'd2;
    localparam logic [DRIVE_W-1:0] DRIVE_RIGHT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENTLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd4;

    // speed selectors of the patterns
    localparam logic [1:0] SPD_SLOW   = 2'd0;
    localparam logic [1:0] SPD_GENTLE = 2'd1;
    localparam logic [1:0] SPD_SHARP  = 2'd2;
    localparam logic [1:0] SPD_CORNER = 2'd3;

    localparam logic [SPEED_W-1:0] RST_SLOW   = 7'd15;
    localparam logic [SPEED_W-1:0] RST_GENTLE = 7'd50;
    localparam logic [SPEED_W-1:0] RST_SHARP  = 7'd80;
    localparam logic [SPEED_W-1:0] RST_CORNER = 7'd85;
    localparam logic [SPEED_W-1:0] RST_START  = 7'd20;

    // all four sensors on the line
    localparam logic [CODE_W-1:0] CODE_ALL = 4'hF;

    typedef struct packed {
        logic [SPEED_W-1:0] slow;
        logic [SPEED_W-1:0] gentle;
        logic [SPEED_W-1:0] sharp;
        logic [SPEED_W-1:0] corner;
        logic [SPEED_W-1:0] start;
    } t_speeds;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [SPEED_W-1:0] speed;
        logic               holding;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [DRIVE_W-1:0] drive;
        logic [1:0]         spd;
        logic [CODE_W-1:0]  exit_hi;
        logic [CODE_W-1:0]  exit_lo;
    } t_pat;

    // Sensor code bits are L ML MR R from msb to lsb. A hold ends when any
    // exit_hi bit is set or any exit_lo bit is clear.
    function automatic t_pat pat_lookup(input logic [HOLD_W-1:0] idx);
        t_pat p;
        p = '0;
        case (idx)
            4'd0: p = '{4'h0, DRIVE_FORWARD, SPD_SLOW,   4'h0, 4'h0};
            4'd1: p = '{4'h6, DRIVE_FORWARD, SPD_SLOW,   4'h0, 4'h6};
            4'd2: p = '{4'h4, DRIVE_LEFT,    SPD_GENTLE, 4'h3, 4'h4};
            4'd3: p = '{4'h2, DRIVE_RIGHT,   SPD_GENTLE, 4'hC, 4'h2};
            4'd4: p = '{4'h8, DRIVE_LEFT,    SPD_SHARP,  4'h7, 4'h0};
            4'd5: p = '{4'hC, DRIVE_LEFT,    SPD_SHARP,  4'h3, 4'h0};
            4'd6: p = '{4'h1, DRIVE_RIGHT,   SPD_SHARP,  4'hE, 4'h0};
            4'd7: p = '{4'h3, DRIVE_RIGHT,   SPD_SHARP,  4'hC, 4'h0};
            4'd8: p = '{4'h7, DRIVE_RIGHT,   SPD_CORNER, 4'h8, 4'h0};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// File: design/fslts_cfg_regs.sv
`timescale 1ns / 1ps

module fslts_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fslts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fslts_pkg::SPEED_W-1:0]       i_cfg_data,
    output fslts_pkg::t_speeds                  o_speeds,
    output logic                                o_start_wr
);

    fslts_pkg::t_speeds r_speeds;
    fslts_pkg::t_speeds n_speeds;

    always_comb begin
        n_speeds   = r_speeds;
        o_start_wr = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fslts_pkg::CFG_SLOW:   n_speeds.slow   = i_cfg_data;
                fslts_pkg::CFG_GENTLE: n_speeds.gentle = i_cfg_data;
                fslts_pkg::CFG_SHARP:  n_speeds.sharp  = i_cfg_data;
                fslts_pkg::CFG_CORNER: n_speeds.corner = i_cfg_data;
                fslts_pkg::CFG_START: begin
                    n_speeds.start = i_cfg_data;
                    o_start_wr     = 1'b1;
                end
                default: n_speeds = r_speeds;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speeds <= '{fslts_pkg::RST_SLOW, fslts_pkg::RST_GENTLE, fslts_pkg::RST_SHARP,
                          fslts_pkg::RST_CORNER, fslts_pkg::RST_START};
        end else begin
            r_speeds <= n_speeds;
        end
    end

    assign o_speeds = r_speeds;

endmodule

// File: design/fslts_steer.sv
`timescale 1ns / 1ps

module fslts_steer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [fslts_pkg::CODE_W-1:0]    i_code,
    input  fslts_pkg::t_speeds              i_speeds,
    input  logic                            i_start_wr,
    input  logic [fslts_pkg::SPEED_W-1:0]   i_start_data,
    output fslts_pkg::t_result              o_result
);

    logic [fslts_pkg::HOLD_W-1:0]  r_hold;
    logic [fslts_pkg::DRIVE_W-1:0] r_drive;
    logic [fslts_pkg::SPEED_W-1:0] r_speed;
    logic                          r_chosen;

    logic [fslts_pkg::HOLD_W-1:0]  n_hold;
    logic [fslts_pkg::DRIVE_W-1:0] n_drive;
    logic [fslts_pkg::SPEED_W-1:0] n_speed;
    logic                          n_chosen;

    fslts_pkg::t_pat               hold_pat;
    fslts_pkg::t_pat               match_pat;
    logic                          hold_act;
    logic                          leave;
    logic                          do_scan;
    logic [fslts_pkg::HOLD_W-1:0]  first;
    logic                          m_hit;
    logic [fslts_pkg::HOLD_W-1:0]  m_idx;

    function automatic logic [fslts_pkg::SPEED_W-1:0] sel_speed(
        input fslts_pkg::t_speeds s,
        input logic [1:0]         sel
    );
        logic [fslts_pkg::SPEED_W-1:0] v;
        v = s.slow;
        unique case (sel)
            fslts_pkg::SPD_SLOW:   v = s.slow;
            fslts_pkg::SPD_GENTLE: v = s.gentle;
            fslts_pkg::SPD_SHARP:  v = s.sharp;
            fslts_pkg::SPD_CORNER: v = s.corner;
            default:               v = s.slow;
        endcase
        return v;
    endfunction

    // pattern codes are distinct, so at most one matches
    always_comb begin
        m_hit = 1'b0;
        m_idx = '0;
        for (int i = 0; i < fslts_pkg::NPAT; i++) begin
            if (fslts_pkg::pat_lookup(fslts_pkg::HOLD_W'(i)).code == i_code) begin
                m_hit = 1'b1;
                m_idx = fslts_pkg::HOLD_W'(i);
            end
        end
    end

    assign match_pat = fslts_pkg::pat_lookup(m_idx);
    assign hold_pat  = fslts_pkg::pat_lookup(r_hold);
    // a hold code past the last pattern counts as no hold
    assign hold_act  = (r_hold != '0) &&
                       (r_hold < fslts_pkg::HOLD_W'(fslts_pkg::NPAT));
    assign leave     = ((i_code & hold_pat.exit_hi) != '0) ||
                       ((~i_code & hold_pat.exit_lo) != '0);

    always_comb begin
        n_drive  = r_drive;
        n_speed  = r_speed;
        n_chosen = r_chosen;
        n_hold   = hold_act ? r_hold : '0;
        first    = '0;
        do_scan  = 1'b0;
        if (hold_act) begin
            n_drive  = hold_pat.drive;
            n_speed  = sel_speed(i_speeds, hold_pat.spd);
            n_chosen = 1'b1;
            if (leave) begin
                // try only the patterns after the one that was held
                n_hold  = '0;
                first   = r_hold + 1'b1;
                do_scan = 1'b1;
            end
        end else if (i_code == fslts_pkg::CODE_ALL) begin
            n_drive = fslts_pkg::DRIVE_STOP;
        end else begin
            do_scan = 1'b1;
        end
        if (do_scan && m_hit && (m_idx >= first)) begin
            n_drive  = match_pat.drive;
            n_speed  = sel_speed(i_speeds, match_pat.spd);
            n_chosen = 1'b1;
            n_hold   = m_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_drive  <= fslts_pkg::DRIVE_STOP;
            r_speed  <= fslts_pkg::RST_START;
            r_chosen <= 1'b0;
        end else if (i_step) begin
            r_hold   <= n_hold;
            r_drive  <= n_drive;
            r_speed  <= n_speed;
            r_chosen <= n_chosen;
        end else if (i_start_wr && !r_chosen) begin
            r_speed  <= i_start_data;
        end
    end

    assign o_result.drive   = n_drive;
    assign o_result.speed   = n_speed;
    assign o_result.holding = (n_hold != '0);

endmodule

// File: design/four_sensor_line_tracking_steering.sv
`timescale 1ns / 1ps

// Line-tracking steering: one four-sensor sample in, one drive/speed/hold
// result out. A sample is captured in an input register, the pattern match
// and hold update run combinationally against the hold state, and the result
// is captured in an output register, so a new sample is taken every cycle
// unless the output stalls. The hold-state update sets that rate. The user
// must write speed registers through the configuration port while the block
// is idle; the block does not enforce this, and there is no read-back.
module four_sensor_line_tracking_steering (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_sense_left,
    input  logic                                i_sense_mid_left,
    input  logic                                i_sense_mid_right,
    input  logic                                i_sense_right,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fslts_pkg::DRIVE_W-1:0]       o_drive,
    output logic [fslts_pkg::SPEED_W-1:0]       o_speed,
    output logic                                o_holding,
    input  logic                                i_cfg_we,
    input  logic [fslts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fslts_pkg::SPEED_W-1:0]       i_cfg_data
);

    fslts_pkg::t_speeds             speeds;
    logic                           start_wr;
    fslts_pkg::t_result             step_res;

    logic                           r_in_valid;
    logic [fslts_pkg::CODE_W-1:0]   r_code;
    logic                           r_out_valid;
    fslts_pkg::t_result             r_res;

    logic                           advance;
    logic                           in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    fslts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_speeds    (speeds),
        .o_start_wr  (start_wr)
    );

    fslts_steer u_steer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_code       (r_code),
        .i_speeds     (speeds),
        .i_start_wr   (start_wr),
        .i_start_data (i_cfg_data),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: capture on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code <= {i_sense_left, i_sense_mid_left, i_sense_mid_right, i_sense_right};
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_res.drive;
    assign o_speed     = r_res.speed;
    assign o_holding   = r_res.holding;

endmodule
